FILE: rtl/sorted_priority_queue_top_defines.svh
// Assertion macros used by the queue controller.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Checks that a condition holds on every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
package spq_pkg;

   // Default sizes of the queue.
   localparam int QUEUE_DEPTH_DEF   = 32;
   localparam int TAG_BITS_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 8;

   // Request modes.
   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_POP     = 2'd1,
      MODE_UPGRADE = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP,
      OP_MARK,
      OP_SCAN,
      OP_REMOVE,
      OP_CLEAR
   } cell_op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REMOVE,
      ST_REINSERT,
      ST_REPORT
   } state_type;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell #(
   parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_pkg::cell_op_type     op,
   input  logic [TAG_BITS-1:0]      bc_tag,
   input  logic [PRIORITY_BITS-1:0] bc_prio,
   input  logic                     left_keep,
   input  logic                     left_seen,
   input  logic [TAG_BITS-1:0]      left_tag,
   input  logic [PRIORITY_BITS-1:0] left_prio,
   input  logic                     left_valid,
   input  logic [TAG_BITS-1:0]      right_tag,
   input  logic [PRIORITY_BITS-1:0] right_prio,
   input  logic                     right_valid,
   output logic                     keep,
   output logic                     seen,
   output logic [TAG_BITS-1:0]      tag,
   output logic [PRIORITY_BITS-1:0] prio,
   output logic                     valid
);

   logic [TAG_BITS-1:0]      tag_ff, tag_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic                     valid_ff, valid_in;
   logic                     seen_ff, seen_in;
   logic                     match;

   // An entry stays in place on insert when it sorts at or before the new one.
   assign keep  = valid_ff && (prio_ff <= bc_prio);
   assign match = valid_ff && (tag_ff == bc_tag);
   assign seen  = seen_ff;
   assign tag   = tag_ff;
   assign prio  = prio_ff;
   assign valid = valid_ff;

   // Next contents of the cell for each chain command.
   always_comb begin
      tag_in   = tag_ff;
      prio_in  = prio_ff;
      valid_in = valid_ff;
      seen_in  = seen_ff;
      case (op)
         spq_pkg::OP_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  tag_in   = bc_tag;
                  prio_in  = bc_prio;
                  valid_in = 1'b1;
               end else begin
                  tag_in   = left_tag;
                  prio_in  = left_prio;
                  valid_in = left_valid;
               end
            end
         end
         spq_pkg::OP_POP: begin
            tag_in   = right_tag;
            prio_in  = right_prio;
            valid_in = right_valid;
         end
         spq_pkg::OP_MARK: begin
            seen_in = match;
         end
         spq_pkg::OP_SCAN: begin
            seen_in = seen_ff | left_seen;
         end
         spq_pkg::OP_REMOVE: begin
            if (seen_ff) begin
               tag_in   = right_tag;
               prio_in  = right_prio;
               valid_in = right_valid;
            end
         end
         spq_pkg::OP_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            tag_in = tag_ff;
         end
      endcase
   end

   // Valid and match flags are control state; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
      end
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
   end

endmodule

FILE: rtl/spq_ctrl.sv
`include "sorted_priority_queue_top_defines.svh"

module spq_ctrl #(
   parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [TAG_BITS-1:0]      req_patient_tag,
   input  logic [PRIORITY_BITS-1:0] req_priority_req,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [TAG_BITS-1:0]      rsp_popped_tag,
   output logic [TAG_BITS-1:0]      rsp_front_tag,
   output logic [PRIORITY_BITS-1:0] rsp_front_priority,
   output logic                     rsp_is_empty,
   output logic [CNT_BITS-1:0]      rsp_entry_total,
   output spq_pkg::cell_op_type     cell_op,
   output logic [TAG_BITS-1:0]      bc_tag,
   output logic [PRIORITY_BITS-1:0] bc_prio,
   input  logic [TAG_BITS-1:0]      front_tag,
   input  logic [PRIORITY_BITS-1:0] front_prio,
   input  logic                     found
);

   localparam int SCAN_BITS = $clog2(QUEUE_DEPTH);
   localparam logic [SCAN_BITS-1:0] SCAN_LAST = SCAN_BITS'(QUEUE_DEPTH - 2);
   localparam logic [CNT_BITS-1:0]  FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [CNT_BITS-1:0]  ONE_COUNT  = CNT_BITS'(1);

   spq_pkg::state_type         state_ff, state_in;
   spq_pkg::status_type        status_ff, status_in;
   spq_pkg::status_type        rsp_status_ff;
   spq_pkg::mode_type          mode;
   logic [CNT_BITS-1:0]        count_ff, count_in;
   logic [SCAN_BITS-1:0]       scan_ff, scan_in;
   logic [TAG_BITS-1:0]        popped_ff, popped_in;
   logic [TAG_BITS-1:0]        saved_tag_ff, saved_tag_in;
   logic [PRIORITY_BITS-1:0]   saved_prio_ff, saved_prio_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [TAG_BITS-1:0]        rsp_popped_tag_ff;
   logic [TAG_BITS-1:0]        rsp_front_tag_ff;
   logic [PRIORITY_BITS-1:0]   rsp_front_priority_ff;
   logic                       rsp_is_empty_ff;
   logic [CNT_BITS-1:0]        rsp_entry_total_ff;
   logic                       accept;
   logic                       is_full;
   logic                       is_none;
   logic                       rsp_load;

   assign mode      = spq_pkg::mode_type'(req_mode);
   assign req_stall = (state_ff != spq_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == FULL_COUNT);
   assign is_none   = (count_ff == '0);
   assign rsp_load  = (state_ff == spq_pkg::ST_REPORT) && !(rsp_valid_ff && rsp_stall);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (mode == spq_pkg::MODE_UPGRADE) ? spq_pkg::ST_SCAN
                                                          : spq_pkg::ST_REPORT;
            end
         end
         spq_pkg::ST_SCAN: begin
            if (scan_ff == SCAN_LAST) begin
               state_in = spq_pkg::ST_REMOVE;
            end
         end
         spq_pkg::ST_REMOVE: begin
            state_in = found ? spq_pkg::ST_REINSERT : spq_pkg::ST_REPORT;
         end
         spq_pkg::ST_REINSERT: begin
            state_in = spq_pkg::ST_REPORT;
         end
         spq_pkg::ST_REPORT: begin
            if (rsp_load) begin
               state_in = spq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   // Chain command and broadcast operands.
   always_comb begin
      cell_op = spq_pkg::OP_HOLD;
      bc_tag  = saved_tag_ff;
      bc_prio = saved_prio_ff;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            bc_tag  = req_patient_tag;
            bc_prio = req_priority_req;
            if (accept) begin
               case (mode)
                  spq_pkg::MODE_INSERT:  cell_op = is_full ? spq_pkg::OP_HOLD
                                                          : spq_pkg::OP_INSERT;
                  spq_pkg::MODE_POP:     cell_op = is_none ? spq_pkg::OP_HOLD
                                                          : spq_pkg::OP_POP;
                  spq_pkg::MODE_UPGRADE: cell_op = spq_pkg::OP_MARK;
                  spq_pkg::MODE_CLEAR:   cell_op = spq_pkg::OP_CLEAR;
                  default:               cell_op = spq_pkg::OP_HOLD;
               endcase
            end
         end
         spq_pkg::ST_SCAN:     cell_op = spq_pkg::OP_SCAN;
         spq_pkg::ST_REMOVE:   cell_op = found ? spq_pkg::OP_REMOVE : spq_pkg::OP_HOLD;
         spq_pkg::ST_REINSERT: cell_op = spq_pkg::OP_INSERT;
         default:              cell_op = spq_pkg::OP_HOLD;
      endcase
   end

   // Count, status and operand bookkeeping.
   always_comb begin
      count_in      = count_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      scan_in       = '0;
      saved_tag_in  = saved_tag_ff;
      saved_prio_in = saved_prio_ff;
      if (accept) begin
         status_in     = spq_pkg::STATUS_OK;
         popped_in     = '0;
         saved_tag_in  = req_patient_tag;
         saved_prio_in = req_priority_req;
         case (mode)
            spq_pkg::MODE_INSERT: begin
               if (is_full) status_in = spq_pkg::STATUS_FULL;
               else         count_in  = count_ff + ONE_COUNT;
            end
            spq_pkg::MODE_POP: begin
               if (is_none) begin
                  status_in = spq_pkg::STATUS_EMPTY;
               end else begin
                  count_in  = count_ff - ONE_COUNT;
                  popped_in = front_tag;
               end
            end
            spq_pkg::MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      if (state_ff == spq_pkg::ST_SCAN) begin
         scan_in = scan_ff + 1'b1;
      end
      if (state_ff == spq_pkg::ST_REMOVE) begin
         if (found) count_in  = count_ff - ONE_COUNT;
         else       status_in = spq_pkg::STATUS_NOT_FOUND;
      end
      if (state_ff == spq_pkg::ST_REINSERT) begin
         count_in = count_ff + ONE_COUNT;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operand and result registers.
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      saved_tag_ff  <= saved_tag_in;
      saved_prio_ff <= saved_prio_in;
      if (rsp_load) begin
         rsp_status_ff         <= status_ff;
         rsp_popped_tag_ff     <= popped_ff;
         rsp_front_tag_ff      <= is_none ? '0 : front_tag;
         rsp_front_priority_ff <= is_none ? '0 : front_prio;
         rsp_is_empty_ff       <= is_none;
         rsp_entry_total_ff    <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_popped_tag     = rsp_popped_tag_ff;
   assign rsp_front_tag      = rsp_front_tag_ff;
   assign rsp_front_priority = rsp_front_priority_ff;
   assign rsp_is_empty       = rsp_is_empty_ff;
   assign rsp_entry_total    = rsp_entry_total_ff;

   // The entry count never passes the number of cells.
   `SPQ_ASSERT_ALWAYS(a_count_range, count_ff <= FULL_COUNT, "entry count above depth")
   // A scan ends only in the remove step.
   `SPQ_ASSERT_NEXT(a_scan_exit, state_ff == spq_pkg::ST_SCAN,
      state_ff == spq_pkg::ST_SCAN || state_ff == spq_pkg::ST_REMOVE, "bad scan exit")
   // A loaded result shows up as valid in the next cycle.
   `SPQ_ASSERT_NEXT(a_result_loaded, rsp_load, rsp_valid_ff, "result not presented")
   // The empty flag agrees with the reported count.
   `SPQ_ASSERT_ALWAYS(a_empty_flag, !rsp_valid_ff || (rsp_is_empty_ff == (rsp_entry_total_ff == '0)),
      "empty flag disagrees with count")

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// Insert, pop and clear go from the idle state to the report state, which loads the result.
// Upgrade moves the tag-match flag one cell per cycle along the chain in the scan state, then
// removes the entry and places it again before the report; a missing tag skips the placing.
// A new transaction is accepted once the previous result is in the output register.
// Synchronous reset empties the queue at once: it clears the valid bits, count and controller.
module sorted_priority_queue_top #(
   parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [TAG_BITS-1:0]      req_patient_tag,
   input  logic [PRIORITY_BITS-1:0] req_priority_req,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [TAG_BITS-1:0]      rsp_popped_tag,
   output logic [TAG_BITS-1:0]      rsp_front_tag,
   output logic [PRIORITY_BITS-1:0] rsp_front_priority,
   output logic                     rsp_is_empty,
   output logic [CNT_BITS-1:0]      rsp_entry_total
);

   spq_pkg::cell_op_type     cell_op;
   logic [TAG_BITS-1:0]      bc_tag;
   logic [PRIORITY_BITS-1:0] bc_prio;
   logic [TAG_BITS-1:0]      tag_w   [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] prio_w  [QUEUE_DEPTH];
   logic                     valid_w [QUEUE_DEPTH];
   logic                     keep_w  [QUEUE_DEPTH];
   logic                     seen_w  [QUEUE_DEPTH];

   // Controller with the count and the result register.
   spq_ctrl #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .TAG_BITS      (TAG_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_patient_tag    (req_patient_tag),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_popped_tag     (rsp_popped_tag),
      .rsp_front_tag      (rsp_front_tag),
      .rsp_front_priority (rsp_front_priority),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_entry_total    (rsp_entry_total),
      .cell_op            (cell_op),
      .bc_tag             (bc_tag),
      .bc_prio            (bc_prio),
      .front_tag          (tag_w[0]),
      .front_prio         (prio_w[0]),
      .found              (seen_w[QUEUE_DEPTH-1])
   );

   // Sorted chain of cells; cell zero is the front of the queue.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                     left_keep;
      logic                     left_seen;
      logic [TAG_BITS-1:0]      left_tag;
      logic [PRIORITY_BITS-1:0] left_prio;
      logic                     left_valid;
      logic [TAG_BITS-1:0]      right_tag;
      logic [PRIORITY_BITS-1:0] right_prio;
      logic                     right_valid;

      // The front cell sees a neighbor that always keeps its place and holds no entry.
      if (i == 0) begin : g_front
         assign left_keep  = 1'b1;
         assign left_seen  = 1'b0;
         assign left_tag   = '0;
         assign left_prio  = '0;
         assign left_valid = 1'b0;
      end else begin : g_inner
         assign left_keep  = keep_w[i-1];
         assign left_seen  = seen_w[i-1];
         assign left_tag   = tag_w[i-1];
         assign left_prio  = prio_w[i-1];
         assign left_valid = valid_w[i-1];
      end

      // The back cell receives an empty entry when the chain shifts forward.
      if (i == QUEUE_DEPTH - 1) begin : g_back
         assign right_tag   = '0;
         assign right_prio  = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid
         assign right_tag   = tag_w[i+1];
         assign right_prio  = prio_w[i+1];
         assign right_valid = valid_w[i+1];
      end

      spq_cell #(
         .TAG_BITS      (TAG_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (cell_op),
         .bc_tag      (bc_tag),
         .bc_prio     (bc_prio),
         .left_keep   (left_keep),
         .left_seen   (left_seen),
         .left_tag    (left_tag),
         .left_prio   (left_prio),
         .left_valid  (left_valid),
         .right_tag   (right_tag),
         .right_prio  (right_prio),
         .right_valid (right_valid),
         .keep        (keep_w[i]),
         .seen        (seen_w[i]),
         .tag         (tag_w[i]),
         .prio        (prio_w[i]),
         .valid       (valid_w[i])
      );
   end

endmodule

FILE: test/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

   localparam int DEPTH  = spq_pkg::QUEUE_DEPTH_DEF;
   localparam int TAG_W  = spq_pkg::TAG_BITS_DEF;
   localparam int PRIO_W = spq_pkg::PRIORITY_BITS_DEF;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Longest upgrade takes the tag match through every cell, plus margin.
   localparam int SETTLE_CYCLES = DEPTH + 16;

   // Fields of one expected result.
   typedef struct packed {
      spq_pkg::status_type status;
      logic [TAG_W-1:0]    popped_tag;
      logic [TAG_W-1:0]    front_tag;
      logic [PRIO_W-1:0]   front_priority;
      logic                is_empty;
      logic [CNT_W-1:0]    entry_total;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_mode = spq_pkg::MODE_INSERT;
   logic [TAG_W-1:0]    req_patient_tag = '0;
   logic [PRIO_W-1:0]   req_priority_req = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [TAG_W-1:0]    rsp_popped_tag;
   logic [TAG_W-1:0]    rsp_front_tag;
   logic [PRIO_W-1:0]   rsp_front_priority;
   logic                rsp_is_empty;
   logic [CNT_W-1:0]    rsp_entry_total;

   // Shadow copy of the sorted queue, updated as each transaction is accepted.
   logic [TAG_W-1:0]    shadow_tag [DEPTH];
   logic [PRIO_W-1:0]   shadow_prio [DEPTH];
   int                  shadow_count = 0;

   outcome_type         pending_outcomes [$];
   int                  mismatch_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  hold_off_cycles = 0;

   sorted_priority_queue_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_patient_tag    (req_patient_tag),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_popped_tag     (rsp_popped_tag),
      .rsp_front_tag      (rsp_front_tag),
      .rsp_front_priority (rsp_front_priority),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_entry_total    (rsp_entry_total)
   );

   // Free-running clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Print one line per mismatch and count every one.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Place an entry behind every entry whose priority is less than or equal to its own.
   function automatic void shadow_place(input logic [TAG_W-1:0] tag,
                                        input logic [PRIO_W-1:0] prio);
      int pos;
      pos = 0;
      while (pos < shadow_count && shadow_prio[pos] <= prio)
         pos++;
      for (int i = shadow_count; i > pos; i--) begin
         shadow_tag[i]  = shadow_tag[i-1];
         shadow_prio[i] = shadow_prio[i-1];
      end
      shadow_tag[pos]  = tag;
      shadow_prio[pos] = prio;
      shadow_count++;
   endfunction

   // Close the gap left by the entry at pos.
   function automatic void shadow_remove(input int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_tag[i]  = shadow_tag[i+1];
         shadow_prio[i] = shadow_prio[i+1];
      end
      shadow_count--;
   endfunction

   // Apply one request to the shadow queue and return the result it must produce.
   function automatic outcome_type queue_outcome(input spq_pkg::mode_type mode,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic [PRIO_W-1:0] prio);
      outcome_type res;
      int          hit;
      res = '0;
      res.status = spq_pkg::STATUS_OK;
      case (mode)
         spq_pkg::MODE_INSERT: begin
            if (shadow_count >= DEPTH)
               res.status = spq_pkg::STATUS_FULL;
            else
               shadow_place(tag, prio);
         end
         spq_pkg::MODE_POP: begin
            if (shadow_count == 0) begin
               res.status = spq_pkg::STATUS_EMPTY;
            end else begin
               res.popped_tag = shadow_tag[0];
               shadow_remove(0);
            end
         end
         spq_pkg::MODE_UPGRADE: begin
            // Only the matching entry nearest the front is re-placed.
            hit = -1;
            for (int i = 0; i < shadow_count; i++) begin
               if (hit < 0 && shadow_tag[i] == tag)
                  hit = i;
            end
            if (hit < 0) begin
               res.status = spq_pkg::STATUS_NOT_FOUND;
            end else begin
               shadow_remove(hit);
               shadow_place(tag, prio);
            end
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      if (shadow_count == 0) begin
         res.is_empty = 1'b1;
      end else begin
         res.front_tag      = shadow_tag[0];
         res.front_priority = shadow_prio[0];
      end
      res.entry_total = CNT_W'(shadow_count);
      return res;
   endfunction

   // Offer one transaction, hold it until accepted, then record its expected result.
   task automatic send_request(input spq_pkg::mode_type mode, input logic [TAG_W-1:0] tag,
                               input logic [PRIO_W-1:0] prio);
      // Each cycle the sender idles with the configured chance.
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_mode         = mode;
      req_patient_tag  = tag;
      req_priority_req = prio;
      do
         @(posedge clock);
      while (req_stall);
      pending_outcomes.push_back(queue_outcome(mode, tag, prio));
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Result side stalls at random, or for a long stretch when a hold-off is requested.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_off_cycles--;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result with no request outstanding, status", 32'(rsp_status),
                            32'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_popped_tag !== want.popped_tag)
               report_mismatch("popped_tag", 32'(rsp_popped_tag), 32'(want.popped_tag));
            if (rsp_front_tag !== want.front_tag)
               report_mismatch("front_tag", 32'(rsp_front_tag), 32'(want.front_tag));
            if (rsp_front_priority !== want.front_priority)
               report_mismatch("front_priority", 32'(rsp_front_priority),
                               32'(want.front_priority));
            if (rsp_is_empty !== want.is_empty)
               report_mismatch("is_empty", 32'(rsp_is_empty), 32'(want.is_empty));
            if (rsp_entry_total !== want.entry_total)
               report_mismatch("entry_total", 32'(rsp_entry_total), 32'(want.entry_total));
         end
      end
   end

   // Extremes, ties, duplicate tags and the empty and not-found error cases, one by one.
   task automatic test_directed_cases();
      send_request(spq_pkg::MODE_POP,     16'h0000, 8'h00);   // pop on an empty queue
      send_request(spq_pkg::MODE_UPGRADE, 16'h0005, 8'h10);   // upgrade with nothing held
      send_request(spq_pkg::MODE_INSERT,  16'hFFFF, 8'hFF);
      send_request(spq_pkg::MODE_INSERT,  16'h0000, 8'h00);
      send_request(spq_pkg::MODE_INSERT,  16'h1234, 8'h50);
      send_request(spq_pkg::MODE_INSERT,  16'h1235, 8'h50);   // ties keep arrival order
      send_request(spq_pkg::MODE_INSERT,  16'h0007, 8'h50);
      send_request(spq_pkg::MODE_UPGRADE, 16'h0007, 8'h50);   // same priority goes behind
      send_request(spq_pkg::MODE_UPGRADE, 16'h1234, 8'h50);
      send_request(spq_pkg::MODE_UPGRADE, 16'hFFFF, 8'h00);   // moves toward the front
      send_request(spq_pkg::MODE_UPGRADE, 16'h0000, 8'hFF);   // moves to the back
      send_request(spq_pkg::MODE_INSERT,  16'h1235, 8'h0A);   // duplicate tag
      send_request(spq_pkg::MODE_UPGRADE, 16'h1235, 8'hC8);   // only the copy nearest front
      send_request(spq_pkg::MODE_UPGRADE, 16'h9999, 8'h01);   // tag not held
      send_request(spq_pkg::MODE_POP,     16'hFFFF, 8'hFF);
      send_request(spq_pkg::MODE_POP,     16'h0000, 8'h00);
      send_request(spq_pkg::MODE_CLEAR,   16'h0000, 8'h00);
      send_request(spq_pkg::MODE_POP,     16'h0000, 8'h00);
      send_request(spq_pkg::MODE_UPGRADE, 16'h1235, 8'h00);
      send_request(spq_pkg::MODE_INSERT,  16'hA5A5, 8'h5A);
      send_request(spq_pkg::MODE_INSERT,  16'h5A5A, 8'hA5);
      send_request(spq_pkg::MODE_CLEAR,   16'hFFFF, 8'hFF);   // fields are ignored on clear
   endtask

   // Fill the queue, insert past full, work on it while full, then drain past empty.
   task automatic test_full_queue();
      logic [TAG_W-1:0] tag;
      for (int i = 0; i < DEPTH; i++)
         send_request(spq_pkg::MODE_INSERT, TAG_W'($urandom), PRIO_W'($urandom_range(0, 15)));
      send_request(spq_pkg::MODE_INSERT, 16'hFFFF, 8'h00);
      send_request(spq_pkg::MODE_INSERT, TAG_W'($urandom), PRIO_W'($urandom));
      tag = shadow_tag[$urandom_range(0, shadow_count - 1)];
      send_request(spq_pkg::MODE_UPGRADE, tag, PRIO_W'($urandom));
      tag = shadow_tag[shadow_count - 1];
      send_request(spq_pkg::MODE_UPGRADE, tag, 8'h00);
      send_request(spq_pkg::MODE_UPGRADE, 16'hFFFF, 8'hFF);
      send_request(spq_pkg::MODE_POP, TAG_W'($urandom), PRIO_W'($urandom));
      send_request(spq_pkg::MODE_INSERT, TAG_W'($urandom), 8'hFF);
      for (int i = 0; i < DEPTH + 1; i++)
         send_request(spq_pkg::MODE_POP, TAG_W'($urandom), PRIO_W'($urandom));
   endtask

   // Mostly well-formed traffic: upgrades aim at held tags, tags and priorities often collide.
   task automatic test_random_traffic(input int count, input int insert_w, input int clear_w);
      int                pick;
      spq_pkg::mode_type mode;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < clear_w)
            mode = spq_pkg::MODE_CLEAR;
         else if (pick < clear_w + insert_w)
            mode = spq_pkg::MODE_INSERT;
         else if ($urandom_range(0, 99) < 55)
            mode = spq_pkg::MODE_POP;
         else
            mode = spq_pkg::MODE_UPGRADE;

         pick = $urandom_range(0, 99);
         if (pick < 30)
            tag = TAG_W'($urandom_range(0, 7));
         else if (pick < 35)
            tag = ($urandom_range(0, 1) != 0) ? '1 : '0;
         else
            tag = TAG_W'($urandom);
         if (mode == spq_pkg::MODE_UPGRADE && shadow_count > 0 && $urandom_range(0, 99) < 85)
            tag = shadow_tag[$urandom_range(0, shadow_count - 1)];

         pick = $urandom_range(0, 99);
         if (pick < 30)
            prio = PRIO_W'($urandom_range(0, 3));
         else if (pick < 40)
            prio = ($urandom_range(0, 1) != 0) ? '1 : '0;
         else
            prio = PRIO_W'($urandom);

         send_request(mode, tag, prio);
      end
   endtask

   // The result side holds off for a long stretch while requests keep coming.
   task automatic test_output_hold_off();
      hold_off_cycles = 150;
      test_random_traffic(20, 60, 0);
      wait_for_results();
   endtask

   // The request side stops until everything outstanding is back, then resumes.
   task automatic test_pause_for_results();
      test_random_traffic(15, 50, 2);
      wait_for_results();
      test_random_traffic(15, 40, 2);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 58;
      test_directed_cases();
      test_full_queue();
      test_random_traffic(180, 60, 1);
      test_random_traffic(180, 40, 4);
      test_output_hold_off();

      send_idle_pct = 58;
      recv_idle_pct = 18;
      test_random_traffic(180, 60, 1);
      test_random_traffic(160, 40, 4);
      test_pause_for_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(180, 60, 1);
      test_random_traffic(180, 40, 4);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         report_mismatch("results still outstanding at end, count", 32'd0,
                         32'(pending_outcomes.size()));

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hard limit on the length of the run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_top.sv
test/sorted_priority_queue_top_tb.sv
